[sv/ffe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffe_pkg - framebuffer fill engine shared definitions
// Request/response payloads, register indexes, shape and pixel mode codes.
// ----------------------------------------------------------------------------
package ffe_pkg;

    localparam int CFG_DIM_W = 13;
    localparam int COORD_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 3;
    localparam int NB_W      = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE    = 2'd3;

    localparam logic [CFG_DIM_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [CFG_DIM_W-1:0] SCREEN_HEIGHT_RST = 13'd480;
    localparam logic [MODE_W-1:0]    PIXEL_MODE_RST    = 3'd4;
    localparam logic [31:0]          FRAME_BASE_RST    = 32'd0;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [1:0] SHAPE_HLINE = 2'd0;
    localparam logic [1:0] SHAPE_VLINE = 2'd1;
    localparam logic [1:0] SHAPE_RECT  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_8BPP  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_15BPP = 3'd1;
    localparam logic [MODE_W-1:0] MODE_16BPP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_24BPP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_32BPP = 3'd4;

    localparam logic [31:0] MASK_1B = 32'h0000_00FF;
    localparam logic [31:0] MASK_2B = 32'h0000_FFFF;
    localparam logic [31:0] MASK_3B = 32'h00FF_FFFF;
    localparam logic [31:0] MASK_4B = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               action;
        logic [1:0]         shape;
        logic [COORD_W-1:0] left_col;
        logic [COORD_W-1:0] top_row;
        logic [COORD_W-1:0] right_col;
        logic [COORD_W-1:0] bottom_row;
        logic [31:0]        fill_value;
    } req_t;

    typedef struct packed {
        logic            write_valid;
        logic [31:0]     write_addr;
        logic [31:0]     write_data;
        logic [NB_W-1:0] byte_count;
        logic            done_res;
        logic            error;
    } rsp_t;

    // walk stage decision, carried to the address stage
    typedef struct packed {
        logic            write;
        logic            done;
        logic            error;
        logic [NB_W-1:0] nbytes;
        logic [31:0]     data;
    } pix_ctl_t;

    function automatic logic [NB_W-1:0] mode_bytes(input logic [MODE_W-1:0] mode);
        logic [NB_W-1:0] nb;
        case (mode)
            MODE_8BPP:  nb = 3'd1;
            MODE_15BPP: nb = 3'd2;
            MODE_16BPP: nb = 3'd2;
            MODE_24BPP: nb = 3'd3;
            MODE_32BPP: nb = 3'd4;
            default:    nb = 3'd0;
        endcase
        return nb;
    endfunction

    function automatic logic [31:0] byte_mask(input logic [NB_W-1:0] nb);
        logic [31:0] m;
        case (nb)
            3'd1:    m = MASK_1B;
            3'd2:    m = MASK_2B;
            3'd3:    m = MASK_3B;
            3'd4:    m = MASK_4B;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

endpackage

[sv/framebuffer_fill_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_fill_engine_unit - solid fill engine for a linear framebuffer
// Start requests load a line or rectangle; each step request returns one
// pixel write (or a done/error status).
// ----------------------------------------------------------------------------
// Every request returns exactly one response; a new request can be taken
// every cycle while the response side is ready. The three stages are the
// request register, the walk stage (span check, walk position and the
// row * width multiply, registered) and the address stage (byte scaling
// plus frame base, into the response register).
// Configuration writes take effect at once and are meant for when the
// engine has no requests in flight.
// ----------------------------------------------------------------------------
module framebuffer_fill_engine_unit #(
    parameter int MAX_DIM = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ffe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_wdata,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  ffe_pkg::req_t                 req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output ffe_pkg::rsp_t                 rsp_data
);

    localparam int DW    = ffe_pkg::CFG_DIM_W;
    localparam int LIM_W = $clog2(MAX_DIM + 1);
    localparam int IDX_W = LIM_W + ffe_pkg::COORD_W;
    localparam logic [DW-1:0] MAX_DIM_C = DW'(MAX_DIM);

    logic [DW-1:0]                 width_reg, height_reg;
    logic [ffe_pkg::MODE_W-1:0]    mode_reg;
    logic [31:0]                   base_reg;

    logic [LIM_W-1:0]              w_lim, h_lim;
    logic [ffe_pkg::NB_W-1:0]      nbytes;

    logic                          s1_valid_reg;
    ffe_pkg::req_t                 s1_item_reg;
    logic                          s2_valid_reg;
    ffe_pkg::pix_ctl_t             s2_ctl_reg;
    logic [IDX_W-1:0]              s2_idx_reg;
    logic                          rsp_valid_reg;
    ffe_pkg::rsp_t                 rsp_reg, rsp_next;

    ffe_pkg::pix_ctl_t             walk_ctl;
    logic [IDX_W-1:0]              walk_idx;

    logic s3_load, s2_move, s2_load, s1_move, s1_load;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ffe_pkg::SCREEN_WIDTH_RST;
            height_reg <= ffe_pkg::SCREEN_HEIGHT_RST;
            mode_reg   <= ffe_pkg::PIXEL_MODE_RST;
            base_reg   <= ffe_pkg::FRAME_BASE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ffe_pkg::CFG_SCREEN_WIDTH:  width_reg  <= cfg_wdata[DW-1:0];
                ffe_pkg::CFG_SCREEN_HEIGHT: height_reg <= cfg_wdata[DW-1:0];
                ffe_pkg::CFG_PIXEL_MODE:    mode_reg   <= cfg_wdata[ffe_pkg::MODE_W-1:0];
                ffe_pkg::CFG_FRAME_BASE:    base_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_lim  = LIM_W'((width_reg > MAX_DIM_C) ? MAX_DIM_C : width_reg);
    assign h_lim  = LIM_W'((height_reg > MAX_DIM_C) ? MAX_DIM_C : height_reg);
    assign nbytes = ffe_pkg::mode_bytes(mode_reg);

    // ---------------- pipeline flow ----------------
    assign s3_load   = !rsp_valid_reg || rsp_ready;
    assign s2_move   = s2_valid_reg && s3_load;
    assign s2_load   = !s2_valid_reg || s2_move;
    assign s1_move   = s1_valid_reg && s2_load;
    assign s1_load   = !s1_valid_reg || s1_move;
    assign req_ready = s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= req_valid;
            if (s2_load)
                s2_valid_reg <= s1_valid_reg;
            if (s3_load)
                rsp_valid_reg <= s2_valid_reg;
        end
    end

    // request register
    always_ff @(posedge clk)
    begin
        if (req_valid && s1_load)
            s1_item_reg <= req_data;
    end

    // ---------------- walk stage ----------------
    ffe_walk #(
        .LIM_W   (LIM_W)
    ) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_move),
        .item    (s1_item_reg),
        .w_lim   (w_lim),
        .h_lim   (h_lim),
        .nbytes  (nbytes),
        .ctl     (walk_ctl),
        .idx     (walk_idx)
    );

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_ctl_reg <= walk_ctl;
            s2_idx_reg <= walk_idx;
        end
    end

    // ---------------- address stage ----------------
    always_comb
    begin
        logic [31:0] lin;
        logic [31:0] off;
        lin = 32'(s2_idx_reg);
        case (s2_ctl_reg.nbytes)
            3'd1:    off = lin;
            3'd2:    off = lin << 1;
            3'd3:    off = (lin << 1) + lin;
            3'd4:    off = lin << 2;
            default: off = 32'd0;
        endcase
        rsp_next             = '0;
        rsp_next.write_valid = s2_ctl_reg.write;
        rsp_next.done_res    = s2_ctl_reg.done;
        rsp_next.error       = s2_ctl_reg.error;
        if (s2_ctl_reg.write)
        begin
            rsp_next.write_addr = base_reg + off;
            rsp_next.write_data = s2_ctl_reg.data;
            rsp_next.byte_count = s2_ctl_reg.nbytes;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

[sv/ffe_walk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffe_walk - command checker and pixel walker
// Validates start requests, holds the span and the walk position, and
// decides per step request whether a pixel is written. Gives the linear
// pixel index of the current position.
// ----------------------------------------------------------------------------
module ffe_walk #(
    parameter int LIM_W   = 13
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  ffe_pkg::req_t            item,
    input  logic [LIM_W-1:0]         w_lim,
    input  logic [LIM_W-1:0]         h_lim,
    input  logic [ffe_pkg::NB_W-1:0] nbytes,
    output ffe_pkg::pix_ctl_t        ctl,
    output logic [LIM_W+ffe_pkg::COORD_W-1:0] idx
);

    localparam int CW = ffe_pkg::COORD_W;
    localparam int DW = ffe_pkg::CFG_DIM_W;
    localparam int IDX_W = LIM_W + CW;

    logic          busy_reg, busy_next;
    logic [1:0]    shape_reg, shape_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] right_reg, right_next;
    logic [CW-1:0] bottom_reg, bottom_next;
    logic [31:0]   colour_reg, colour_next;

    logic [DW-1:0] w_ext, h_ext;

    assign w_ext = DW'(w_lim);
    assign h_ext = DW'(h_lim);

    // row * width + col, registered by the caller before the byte scaling
    assign idx = IDX_W'(w_lim) * IDX_W'(row_reg) + IDX_W'(col_reg);

    always_comb
    begin
        logic [CW-1:0] l, t, r, b;
        logic          bad;
        busy_next   = busy_reg;
        shape_next  = shape_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        colour_next = colour_reg;
        ctl         = '0;
        l   = item.left_col;
        t   = item.top_row;
        r   = item.right_col;
        b   = item.bottom_row;
        bad = 1'b0;

        if (item.action == ffe_pkg::ACT_START)
        begin
            busy_next = 1'b0;
            case (item.shape)
                ffe_pkg::SHAPE_HLINE:
                begin
                    bad = DW'(l) >= w_ext || DW'(r) >= w_ext || DW'(t) >= h_ext;
                    b   = t;
                end
                ffe_pkg::SHAPE_VLINE:
                begin
                    bad = DW'(l) >= w_ext || DW'(t) >= h_ext || DW'(b) >= h_ext;
                    r   = l;
                end
                ffe_pkg::SHAPE_RECT:
                begin
                    bad = DW'(l) >= w_ext || DW'(t) >= h_ext;
                    // clamp to last column; width is non-zero here
                    if (!bad && DW'(r) >= w_ext)
                        r = CW'(w_ext - DW'(1));
                end
                default: bad = 1'b1;
            endcase
            if (nbytes == '0)
                bad = 1'b1;

            if (bad)
            begin
                ctl.done  = 1'b1;
                ctl.error = 1'b1;
            end
            else if (r < l || b < t)
            begin
                ctl.done = 1'b1;
            end
            else
            begin
                busy_next   = 1'b1;
                shape_next  = item.shape;
                col_next    = l;
                row_next    = t;
                left_next   = l;
                right_next  = r;
                bottom_next = b;
                colour_next = item.fill_value;
            end
        end
        else if (!busy_reg)
        begin
            ctl.done = 1'b1;
        end
        else if (nbytes == '0 || DW'(col_reg) >= w_ext || DW'(row_reg) >= h_ext)
        begin
            busy_next = 1'b0;
            ctl.done  = 1'b1;
            ctl.error = 1'b1;
        end
        else
        begin
            ctl.write  = 1'b1;
            ctl.nbytes = nbytes;
            ctl.data   = colour_reg & ffe_pkg::byte_mask(nbytes);
            if (col_reg == right_reg)
            begin
                if (row_reg == bottom_reg)
                begin
                    busy_next = 1'b0;
                    ctl.done  = 1'b1;
                end
                else
                begin
                    col_next = left_reg;
                    row_next = row_reg + CW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            shape_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            colour_reg <= '0;
        end
        else if (advance)
        begin
            busy_reg   <= busy_next;
            shape_reg  <= shape_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            colour_reg <= colour_next;
        end
    end

endmodule

[sv/ffe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffe_checker - port level checks for the fill engine
// Watches the response channel and the payload rules of the responses.
// ----------------------------------------------------------------------------
module ffe_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input ffe_pkg::rsp_t rsp_data
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // no write: address, data and count are zero
    a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.write_valid |->
            rsp_data.write_addr == 32'd0 && rsp_data.write_data == 32'd0 &&
            rsp_data.byte_count == 3'd0)
        else $error("non-write response carries payload");

    // a write has a legal byte count and never flags an error
    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.write_valid |->
            rsp_data.byte_count != 3'd0 && rsp_data.byte_count <= 3'd4 &&
            !rsp_data.error)
        else $error("bad pixel write");

    // an error always ends the command
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.error |-> rsp_data.done_res)
        else $error("error without done");

    // a request taken into an empty engine shows no response next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !rsp_valid |=> !rsp_valid || $past(rsp_valid) ||
            !$past(req_ready, 2) || $past(req_valid, 2) || $past(req_valid, 3))
        else $error("response appeared too early");

endmodule

bind framebuffer_fill_engine_unit ffe_checker u_ffe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for framebuffer_fill_engine_unit
// Drives start/step requests through the valid/ready request channel, keeps a
// cycle-free model of the fill walk to predict every response, and compares
// each accepted response field by field. A short directed run covers screen
// edges, rejects, clamping, empty spans and settings changed mid-command;
// random phases then sweep screen sizes, pixel modes and frame bases with
// bursty request traffic and an irregular response stall pattern.
// ----------------------------------------------------------------------------
module tb;

    localparam int          MAX_DIM       = 4096;
    localparam int          RANDOM_ITEMS  = 750;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          LONG_HOLD     = 400;
    localparam logic [1:0]  SHAPE_BAD     = 2'd3;
    localparam logic [2:0]  MODE_LAST     = 3'd7;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_TOGGLE} ready_pat_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [ffe_pkg::CFG_IDX_W-1:0] cfg_index = ffe_pkg::CFG_SCREEN_WIDTH;
    logic [31:0]                   cfg_wdata = '0;
    logic                          req_valid = 1'b0;
    logic                          req_ready;
    ffe_pkg::req_t                 req_data  = '0;
    logic                          rsp_valid;
    logic                          rsp_ready = 1'b0;
    ffe_pkg::rsp_t                 rsp_data;

    // settings as last written
    logic [12:0] scr_width  = ffe_pkg::SCREEN_WIDTH_RST;
    logic [12:0] scr_height = ffe_pkg::SCREEN_HEIGHT_RST;
    logic [2:0]  pix_mode   = ffe_pkg::PIXEL_MODE_RST;
    logic [31:0] fb_base    = ffe_pkg::FRAME_BASE_RST;

    // fill walk state
    logic        eng_busy   = 1'b0;
    logic [11:0] eng_col    = '0;
    logic [11:0] eng_row    = '0;
    logic [11:0] eng_left   = '0;
    logic [11:0] eng_right  = '0;
    logic [11:0] eng_bottom = '0;
    logic [31:0] eng_colour = '0;

    ffe_pkg::req_t queued_reqs[$];
    ffe_pkg::rsp_t awaited_rsp[$];
    int   mismatches = 0;
    int   rsp_seen   = 0;
    int   issued     = 0;

    int         burst_left   = 1;
    int         gap_left     = 0;
    int         stall_asks   = 0;
    int         stall_served = 0;
    int         hold_left    = 0;
    int         pat_left     = 0;
    ready_pat_t ready_pat    = RDY_ALWAYS;

    framebuffer_fill_engine_unit #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data (rsp_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic ffe_pkg::rsp_t fill_engine_response(ffe_pkg::req_t r);
        ffe_pkg::rsp_t o;
        int unsigned   w, h, nb, lc, tr, rc, br;
        logic          rejected;
        o  = '0;
        w  = (scr_width > MAX_DIM) ? MAX_DIM : scr_width;
        h  = (scr_height > MAX_DIM) ? MAX_DIM : scr_height;
        case (pix_mode)
            ffe_pkg::MODE_8BPP:                       nb = 1;
            ffe_pkg::MODE_15BPP, ffe_pkg::MODE_16BPP: nb = 2;
            ffe_pkg::MODE_24BPP:                      nb = 3;
            ffe_pkg::MODE_32BPP:                      nb = 4;
            default:                                  nb = 0;
        endcase
        if (r.action == ffe_pkg::ACT_START)
        begin
            lc = r.left_col;
            tr = r.top_row;
            rc = r.right_col;
            br = r.bottom_row;
            eng_busy = 1'b0;
            case (r.shape)
                ffe_pkg::SHAPE_HLINE:
                begin
                    rejected = (lc >= w) || (rc >= w) || (tr >= h);
                    br = tr;
                end
                ffe_pkg::SHAPE_VLINE:
                begin
                    rejected = (lc >= w) || (tr >= h) || (br >= h);
                    rc = lc;
                end
                ffe_pkg::SHAPE_RECT:
                begin
                    rejected = (lc >= w) || (tr >= h);
                    if (!rejected && rc >= w)
                        rc = w - 1;
                end
                default: rejected = 1'b1;
            endcase
            if (nb == 0)
                rejected = 1'b1;
            if (rejected)
            begin
                o.done_res = 1'b1;
                o.error    = 1'b1;
            end
            else if (rc < lc || br < tr)
            begin
                o.done_res = 1'b1;
            end
            else
            begin
                eng_col    = lc;
                eng_row    = tr;
                eng_left   = lc;
                eng_right  = rc;
                eng_bottom = br;
                eng_colour = r.fill_value;
                eng_busy   = 1'b1;
            end
        end
        else if (!eng_busy)
        begin
            o.done_res = 1'b1;
        end
        else if (nb == 0 || eng_col >= w || eng_row >= h)
        begin
            // settings changed under the command, or a rect row below the screen
            eng_busy   = 1'b0;
            o.done_res = 1'b1;
            o.error    = 1'b1;
        end
        else
        begin
            o.write_valid = 1'b1;
            o.write_addr  = fb_base + nb * (w * eng_row + eng_col);
            o.write_data  = (nb == 4) ? eng_colour : eng_colour & ((32'd1 << (8 * nb)) - 1);
            o.byte_count  = 3'(nb);
            if (eng_col == eng_right)
            begin
                if (eng_row == eng_bottom)
                begin
                    o.done_res = 1'b1;
                    eng_busy   = 1'b0;
                end
                else
                begin
                    eng_col = eng_left;
                    eng_row = eng_row + 12'd1;
                end
            end
            else
            begin
                eng_col = eng_col + 12'd1;
            end
        end
        return o;
    endfunction

    function automatic logic [11:0] pick_coord(int unsigned bound);
        case ($urandom_range(0, 9))
            0:       return 12'd0;
            1:       return 12'hFFF;
            2:       return (bound == 0) ? 12'd0 : 12'(bound - 1);
            3:       return (bound >= MAX_DIM) ? 12'hFFF : 12'($urandom_range(bound, MAX_DIM - 1));
            default: return (bound == 0) ? 12'($urandom) : 12'($urandom_range(0, bound - 1));
        endcase
    endfunction

    function automatic ffe_pkg::req_t make_start(logic [1:0] shp, logic [11:0] lc,
                                                 logic [11:0] tr, logic [11:0] rc,
                                                 logic [11:0] br, logic [31:0] fill);
        ffe_pkg::req_t s;
        s.action     = ffe_pkg::ACT_START;
        s.shape      = shp;
        s.left_col   = lc;
        s.top_row    = tr;
        s.right_col  = rc;
        s.bottom_row = br;
        s.fill_value = fill;
        return s;
    endfunction

    // step requests carry junk in the unused fields
    function automatic ffe_pkg::req_t make_step();
        ffe_pkg::req_t s;
        s.action     = ffe_pkg::ACT_STEP;
        s.shape      = 2'($urandom_range(0, 3));
        s.left_col   = 12'($urandom);
        s.top_row    = 12'($urandom);
        s.right_col  = 12'($urandom);
        s.bottom_row = 12'($urandom);
        s.fill_value = $urandom;
        return s;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_response(ffe_pkg::rsp_t got);
        ffe_pkg::rsp_t want;
        if (awaited_rsp.size() == 0)
        begin
            flag_mismatch($sformatf("response %0d with nothing outstanding: %p", rsp_seen, got));
        end
        else
        begin
            want = awaited_rsp.pop_front();
            if (got.write_valid !== want.write_valid)
                flag_mismatch($sformatf("response %0d write_valid %b, want %b",
                                        rsp_seen, got.write_valid, want.write_valid));
            if (got.write_addr !== want.write_addr)
                flag_mismatch($sformatf("response %0d write_addr %h, want %h",
                                        rsp_seen, got.write_addr, want.write_addr));
            if (got.write_data !== want.write_data)
                flag_mismatch($sformatf("response %0d write_data %h, want %h",
                                        rsp_seen, got.write_data, want.write_data));
            if (got.byte_count !== want.byte_count)
                flag_mismatch($sformatf("response %0d byte_count %0d, want %0d",
                                        rsp_seen, got.byte_count, want.byte_count));
            if (got.done_res !== want.done_res)
                flag_mismatch($sformatf("response %0d done_res %b, want %b",
                                        rsp_seen, got.done_res, want.done_res));
            if (got.error !== want.error)
                flag_mismatch($sformatf("response %0d error %b, want %b",
                                        rsp_seen, got.error, want.error));
        end
        rsp_seen++;
    endtask

    // idle once every queued request has been sent and answered
    task automatic wait_idle();
        while (queued_reqs.size() != 0 || rsp_seen != issued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(int unsigned w, int unsigned h, logic [2:0] mode,
                                  logic [31:0] base);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= ffe_pkg::CFG_SCREEN_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_index <= ffe_pkg::CFG_SCREEN_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_index <= ffe_pkg::CFG_PIXEL_MODE;
        cfg_wdata <= 32'(mode);
        @(posedge clk);
        cfg_index <= ffe_pkg::CFG_FRAME_BASE;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_we    <= 1'b0;
        scr_width  = 13'(w);
        scr_height = 13'(h);
        pix_mode   = mode;
        fb_base    = base;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
                awaited_rsp.push_back(fill_engine_response(req_data));
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (queued_reqs.size() != 0)
                begin
                    req_valid <= 1'b1;
                    req_data  <= queued_reqs.pop_front();
                    issued++;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
                check_response(rsp_data);
            if (stall_asks != stall_served)
            begin
                stall_served = stall_asks;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (pat_left <= 0)
                begin
                    ready_pat = ready_pat_t'($urandom_range(0, 3));
                    pat_left  = $urandom_range(8, 80);
                end
                pat_left--;
                case (ready_pat)
                    RDY_ALWAYS: rsp_ready <= 1'b1;
                    RDY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
                    RDY_RARELY: rsp_ready <= ($urandom_range(0, 3) == 0);
                    default:    rsp_ready <= ~rsp_ready;
                endcase
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int unsigned w, h, w_eff, h_eff, dx, dy, steps;
        logic [2:0]    mode;
        logic [31:0]   base, fill;
        logic [1:0]    shp;
        logic [11:0]   lc, tr, rc, br;
        ffe_pkg::req_t noise;
        int            phase, phase_items, quota, rand_items;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, 640x480 at 32bpp
        queued_reqs.push_back(make_step());
        queued_reqs.push_back(make_start(ffe_pkg::SHAPE_HLINE, 12'd0, 12'd0, 12'd3, 12'd0, '1));
        repeat (4) queued_reqs.push_back(make_step());
        queued_reqs.push_back(make_start(ffe_pkg::SHAPE_VLINE, 12'd639, 12'd477, 12'd0,
                                         12'd479, 32'h1234_5678));
        repeat (3) queued_reqs.push_back(make_step());
        // right edge clamps, last row runs off the bottom
        queued_reqs.push_back(make_start(ffe_pkg::SHAPE_RECT, 12'd637, 12'd478, 12'hFFF,
                                         12'hFFF, '0));
        repeat (7) queued_reqs.push_back(make_step());
        queued_reqs.push_back(make_start(ffe_pkg::SHAPE_HLINE, 12'd0, 12'd0, 12'd640, 12'd0,
                                         $urandom));
        queued_reqs.push_back(make_start(ffe_pkg::SHAPE_VLINE, 12'd5, 12'd0, 12'd5, 12'd480,
                                         $urandom));
        queued_reqs.push_back(make_start(SHAPE_BAD, 12'd0, 12'd0, 12'd1, 12'd1, $urandom));
        queued_reqs.push_back(make_start(ffe_pkg::SHAPE_RECT, 12'd5, 12'd5, 12'd4, 12'd9,
                                         $urandom));
        queued_reqs.push_back(make_start(ffe_pkg::SHAPE_RECT, 12'd0, 12'd0, 12'd2, 12'd2,
                                         32'hA5C3_0F96));
        queued_reqs.push_back(make_step());
        wait_idle();
        // unsupported mode with a command still armed
        apply_settings(640, 480, ffe_pkg::MODE_32BPP + 3'd1, 32'h0);
        queued_reqs.push_back(make_step());
        queued_reqs.push_back(make_start(ffe_pkg::SHAPE_HLINE, 12'd0, 12'd0, 12'd1, 12'd0,
                                         $urandom));
        queued_reqs.push_back(make_step());
        wait_idle();
        apply_settings(640, 480, ffe_pkg::MODE_32BPP, 32'h0);
        queued_reqs.push_back(make_start(ffe_pkg::SHAPE_VLINE, 12'd600, 12'd0, 12'd0, 12'd5,
                                         $urandom));
        queued_reqs.push_back(make_step());
        wait_idle();
        // screen narrows under the running line
        apply_settings(50, 480, ffe_pkg::MODE_32BPP, 32'h0);
        queued_reqs.push_back(make_step());
        wait_idle();

        rand_items = 0;
        phase      = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            mode = 3'($urandom_range(ffe_pkg::MODE_8BPP, ffe_pkg::MODE_32BPP));
            base = $urandom;
            w    = $urandom_range(16, 64);
            h    = $urandom_range(4, 16);
            case (phase % 10)
                0:
                begin
                    w    = 4096;
                    h    = 4096;
                    mode = ffe_pkg::MODE_8BPP;
                    base = 32'hFFFF_FF00;
                end
                1:
                begin
                    w    = 1;
                    h    = 1;
                    mode = ffe_pkg::MODE_24BPP;
                end
                2:
                begin
                    w    = 8191;
                    h    = 8191;
                    mode = ffe_pkg::MODE_15BPP;
                end
                3: mode = ffe_pkg::MODE_16BPP;
                4:
                begin
                    mode = ffe_pkg::MODE_32BPP;
                    base = '1;
                end
                5: w = 0;
                6: mode = 3'($urandom_range(ffe_pkg::MODE_32BPP + 3'd1, MODE_LAST));
                7:
                begin
                    w = $urandom_range(1, 4096);
                    h = $urandom_range(1, 4096);
                end
                default: ;
            endcase
            apply_settings(w, h, mode, base);
            w_eff = (w > MAX_DIM) ? MAX_DIM : w;
            h_eff = (h > MAX_DIM) ? MAX_DIM : h;
            // long response hold-off while requests keep coming
            if (phase % 10 == 3)
                stall_asks++;
            quota = (w_eff == 0 || mode > ffe_pkg::MODE_32BPP) ? 20 : 70;
            phase_items = 0;
            while (phase_items < quota)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    noise.action     = 1'($urandom_range(0, 1));
                    noise.shape      = 2'($urandom_range(0, 3));
                    noise.left_col   = 12'($urandom);
                    noise.top_row    = 12'($urandom);
                    noise.right_col  = 12'($urandom);
                    noise.bottom_row = 12'($urandom);
                    noise.fill_value = $urandom;
                    queued_reqs.push_back(noise);
                    phase_items++;
                end
                else
                begin
                    case ($urandom_range(0, 19))
                        0:                 shp = SHAPE_BAD;
                        1, 2, 3, 4, 5, 6:  shp = ffe_pkg::SHAPE_HLINE;
                        7, 8, 9, 10, 11:   shp = ffe_pkg::SHAPE_VLINE;
                        default:           shp = ffe_pkg::SHAPE_RECT;
                    endcase
                    lc = pick_coord(w_eff);
                    tr = pick_coord(h_eff);
                    case ($urandom_range(0, 7))
                        0:       rc = lc - 12'd1;
                        1:       rc = pick_coord(w_eff);
                        default: rc = lc + 12'($urandom_range(0, 7));
                    endcase
                    case ($urandom_range(0, 7))
                        0:       br = tr - 12'd1;
                        1:       br = pick_coord(h_eff);
                        default: br = tr + 12'($urandom_range(0, 5));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       fill = '0;
                        1:       fill = '1;
                        default: fill = $urandom;
                    endcase
                    queued_reqs.push_back(make_start(shp, lc, tr, rc, br, fill));
                    dx = (shp == ffe_pkg::SHAPE_VLINE) ? 1 : ((rc >= lc) ? rc - lc + 1 : 0);
                    dy = (shp == ffe_pkg::SHAPE_HLINE) ? 1 : ((br >= tr) ? br - tr + 1 : 0);
                    steps = dx * dy;
                    if (steps > 48)
                        steps = 48;
                    // now and then cut the walk short so the next start abandons it
                    if ($urandom_range(0, 7) == 0)
                        steps = $urandom_range(0, steps);
                    else
                        steps += $urandom_range(0, 2);
                    repeat (steps) queued_reqs.push_back(make_step());
                    phase_items += 1 + steps;
                end
            end
            rand_items += phase_items;
            wait_idle();
            phase++;
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
